// ===== rtl/mau_pkg.sv =====
package mau_pkg;

  typedef enum logic [3:0] {
    ACT_ADD       = 4'd0,
    ACT_SUB       = 4'd1,
    ACT_NEG       = 4'd2,
    ACT_MUL       = 4'd3,
    ACT_MAC       = 4'd4,
    ACT_MONT_RED  = 4'd5,
    ACT_TO_MONT   = 4'd6,
    ACT_FROM_MONT = 4'd7,
    ACT_INV       = 4'd8
  } act_e;

  typedef enum logic [1:0] {
    CFG_MODULUS   = 2'd0,
    CFG_N_PRIME   = 2'd1,
    CFG_R_SQUARED = 2'd2,
    CFG_MONT_MODE = 2'd3
  } cfg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISP,
    ST_ALU,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_MAC_LO,
    ST_MAC_HI,
    ST_REM_GO,
    ST_REM_WAIT,
    ST_RD_M_GO,
    ST_RD_M_WAIT,
    ST_RD_N_GO,
    ST_RD_N_WAIT,
    ST_RD_UPD,
    ST_RD_FIN,
    ST_INV_CHK,
    ST_INV_DIV_GO,
    ST_INV_DIV_WAIT,
    ST_INV_MUL_GO,
    ST_INV_MUL_WAIT,
    ST_INV_FIN,
    ST_DONE
  } state_e;

  localparam logic [63:0] MODULUS_RST   = 64'hFFFF_FFFF_0000_0001;
  localparam logic [31:0] N_PRIME_RST   = 32'hFFFF_FFFF;
  localparam logic [63:0] R_SQUARED_RST = 64'hFFFF_FFFE_0000_0001;

  localparam int IN_TDATA_W  = 200;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_DATA_W  = 64;

endpackage

// ===== rtl/mau_mul.sv =====
// Shift-add multiplier, one bit of y per cycle, full double-width product.
module mau_mul import mau_pkg::*; #(
  parameter int W = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   x_i,
  input  logic [W-1:0]   y_i,
  output logic           done_o,
  output logic [2*W-1:0] prod_o
);

  localparam int CW = (W > 1) ? $clog2(W) : 1;

  logic          busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  x_q, x_d, hi_q, hi_d, lo_q, lo_d;
  logic [W:0]    sum;

  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, x_q} : {(W+1){1'b0}});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      x_d    = x_i;
      hi_d   = '0;
      lo_d   = y_i;
    end else if (busy_q) begin
      hi_d  = sum[W:1];
      lo_d  = {sum[0], lo_q[W-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(W-1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

// ===== rtl/mau_div.sv =====
// Restoring divider, one dividend bit per cycle: double-width numerator,
// single-width divisor.
module mau_div import mau_pkg::*; #(
  parameter int W = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [2*W-1:0] num_i,
  input  logic [W-1:0]   den_i,
  output logic           done_o,
  output logic [W-1:0]   quo_o,
  output logic [W-1:0]   rem_o
);

  localparam int CW = $clog2(2*W);

  logic           busy_q, busy_d, done_q, done_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [2*W-1:0] num_q, num_d;
  logic [W-1:0]   den_q, den_d, rem_q, rem_d;
  logic [W:0]     rem2, diff;
  logic           ge;

  assign rem2 = {rem_q, num_q[2*W-1]};
  assign ge   = rem2 >= {1'b0, den_q};
  assign diff = rem2 - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[W-1:0] : rem2[W-1:0];
      num_d = {num_q[2*W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(2*W-1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = num_q[W-1:0];
  assign rem_o  = rem_q;

endmodule

// ===== rtl/modular_arith_unit.sv =====
// Mul and mac use the bit-serial multiplier, then the serial remainder; a
// Montgomery-mode mul takes limb reduction instead. Montgomery ops multiply
// by n' and by the modulus per limb, limbs = ceil(MOD_WIDTH/limb width).
// Inverse: a divide and a multiply per Euclid step, plus a mul in
// Montgomery mode. One transaction at a time; the next is taken while the
// result waits. Reset is asynchronous, active low, loads register defaults.
module modular_arith_unit import mau_pkg::*; #(
  parameter int MOD_WIDTH  = 64,
  parameter int LIMB_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // action[3:0], operand_a[67:4], operand_b[131:68], addend[195:132]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // result_value[63:0]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int W     = MOD_WIDTH;
  localparam int L     = (LIMB_WIDTH < W) ? LIMB_WIDTH : W;
  localparam int COUNT = (W + L - 1) / L;
  localparam int NPW   = (L < 32) ? L : 32;
  localparam int LCW   = $clog2(COUNT) + 1;
  localparam logic [W-1:0] LMASK = {W{1'b1}} >> (W - L);

  state_e state_q, state_d;

  logic [W-1:0]   modulus_q, r2_q;
  logic [NPW-1:0] np_q;
  logic           mode_q;

  act_e           act_q;
  logic [W-1:0]   op_a_q, op_b_q, acc_q, res_q, out_q;
  logic           out_valid_q, out_load;
  logic [2*W-1:0] prod_q;
  logic           carry_q;
  logic [W-1:0]   tlo_q, thi_q;
  logic [L-1:0]   m_q;
  logic [LCW-1:0] limb_q;
  logic [W-1:0]   r0_q, r1_q, t0_q, t1_q, q_q, nr_q;

  logic           mul_start, mul_done, div_start, div_done;
  logic [W-1:0]   mul_x, mul_y, div_den, div_quo, div_rem;
  logic [2*W-1:0] mul_prod, div_num;

  // ALU datapath
  logic [W:0]   add_s, sub_s;
  logic [W-1:0] alu_res;
  // limb step
  logic [W:0]   rd_s;
  logic [W-1:0] rd_thi, rd_tlo;
  logic [W:0]   mac_s;
  logic [W-1:0] inv_res;

  mau_mul #(.W(W)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .x_i(mul_x), .y_i(mul_y),
    .done_o(mul_done), .prod_o(mul_prod)
  );

  mau_div #(.W(W)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo), .rem_o(div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_RST[W-1:0];
      np_q      <= N_PRIME_RST[NPW-1:0];
      r2_q      <= R_SQUARED_RST[W-1:0];
      mode_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_MODULUS:   modulus_q <= cfg_data_i[W-1:0];
        CFG_N_PRIME:   np_q      <= cfg_data_i[NPW-1:0];
        CFG_R_SQUARED: r2_q      <= cfg_data_i[W-1:0];
        CFG_MONT_MODE: mode_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    add_s = {1'b0, op_a_q} + {1'b0, op_b_q};
    sub_s = {1'b0, op_a_q} - {1'b0, op_b_q};
    unique case (act_q)
      ACT_ADD: alu_res = (add_s[W] || add_s[W-1:0] >= modulus_q) ?
                         add_s[W-1:0] - modulus_q : add_s[W-1:0];
      ACT_SUB: alu_res = sub_s[W] ? sub_s[W-1:0] + modulus_q : sub_s[W-1:0];
      ACT_NEG: alu_res = modulus_q - op_a_q;
      default: alu_res = '0;
    endcase
  end

  assign rd_s   = {1'b0, tlo_q} + {1'b0, prod_q[W-1:0]};
  assign rd_thi = thi_q + prod_q[2*W-1:W] + W'(rd_s[W]);
  assign rd_tlo = (COUNT == 1) ? rd_thi :
                  ((rd_s[W-1:0] >> L) | ((rd_thi & LMASK) << ((COUNT-1)*L)));
  assign mac_s  = {1'b0, prod_q[W-1:0]} + {1'b0, acc_q};
  assign inv_res = (r0_q != W'(1)) ? '0 : (t0_q[W-1] ? t0_q + modulus_q : t0_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (s_axis_tvalid) state_d = ST_DISP;
      ST_DISP: begin
        unique case (act_q)
          ACT_MUL:       state_d = mode_q ? ST_MUL_GO : ST_MUL_GO;
          ACT_MAC,
          ACT_TO_MONT:   state_d = ST_MUL_GO;
          ACT_MONT_RED,
          ACT_FROM_MONT: state_d = ST_RD_M_GO;
          ACT_INV:       state_d = ST_INV_CHK;
          default:       state_d = ST_ALU;
        endcase
      end
      ST_ALU:      state_d = ST_DONE;
      ST_MUL_GO:   state_d = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mul_done) begin
          if (act_q == ACT_MAC) state_d = ST_MAC_LO;
          else if (act_q == ACT_TO_MONT || (act_q == ACT_MUL && mode_q))
            state_d = ST_RD_M_GO;
          else state_d = ST_REM_GO;
        end
      end
      ST_MAC_LO:       state_d = ST_MAC_HI;
      ST_MAC_HI:       state_d = ST_REM_GO;
      ST_REM_GO:       state_d = ST_REM_WAIT;
      ST_REM_WAIT:     if (div_done) state_d = ST_DONE;
      ST_RD_M_GO:      state_d = ST_RD_M_WAIT;
      ST_RD_M_WAIT:    if (mul_done) state_d = ST_RD_N_GO;
      ST_RD_N_GO:      state_d = ST_RD_N_WAIT;
      ST_RD_N_WAIT:    if (mul_done) state_d = ST_RD_UPD;
      ST_RD_UPD:       state_d = (limb_q == LCW'(COUNT-1)) ? ST_RD_FIN : ST_RD_M_GO;
      ST_RD_FIN:       state_d = ST_DONE;
      ST_INV_CHK:      state_d = (r1_q == '0) ? ST_INV_FIN : ST_INV_DIV_GO;
      ST_INV_DIV_GO:   state_d = ST_INV_DIV_WAIT;
      ST_INV_DIV_WAIT: if (div_done) state_d = ST_INV_MUL_GO;
      ST_INV_MUL_GO:   state_d = ST_INV_MUL_WAIT;
      ST_INV_MUL_WAIT: if (mul_done) state_d = ST_INV_CHK;
      ST_INV_FIN:      state_d = mode_q ? ST_MUL_GO : ST_DONE;
      ST_DONE:         if (out_load) state_d = ST_IDLE;
      default:         state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
    mul_start     = 1'b0;
    mul_x         = op_a_q;
    mul_y         = op_b_q;
    div_start     = 1'b0;
    div_num       = prod_q;
    div_den       = modulus_q;
    unique case (state_q)
      ST_MUL_GO: mul_start = 1'b1;
      ST_RD_M_GO: begin
        mul_start = 1'b1;
        mul_x     = tlo_q & LMASK;
        mul_y     = W'(np_q);
      end
      ST_RD_N_GO: begin
        mul_start = 1'b1;
        mul_x     = modulus_q;
        mul_y     = W'(m_q);
      end
      ST_INV_MUL_GO: begin
        mul_start = 1'b1;
        mul_x     = t1_q;
        mul_y     = q_q;
      end
      ST_REM_GO: div_start = 1'b1;
      ST_INV_DIV_GO: begin
        div_start = 1'b1;
        div_num   = {{W{1'b0}}, r0_q};
        div_den   = r1_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          act_q  <= act_e'(s_axis_tdata[3:0]);
          op_a_q <= s_axis_tdata[4 +: W];
          op_b_q <= s_axis_tdata[68 +: W];
          acc_q  <= s_axis_tdata[132 +: W];
        end
      end
      ST_DISP: begin
        limb_q <= '0;
        r0_q   <= modulus_q;
        r1_q   <= op_a_q;
        t0_q   <= '0;
        t1_q   <= W'(1);
        tlo_q  <= op_a_q;
        thi_q  <= (act_q == ACT_MONT_RED) ? op_b_q : '0;
        if (act_q == ACT_TO_MONT) op_b_q <= r2_q;
      end
      ST_ALU: res_q <= alu_res;
      ST_MUL_WAIT: begin
        if (mul_done) begin
          prod_q <= mul_prod;
          tlo_q  <= mul_prod[W-1:0];
          thi_q  <= mul_prod[2*W-1:W];
          limb_q <= '0;
        end
      end
      ST_MAC_LO: begin
        prod_q[W-1:0] <= mac_s[W-1:0];
        carry_q       <= mac_s[W];
      end
      ST_MAC_HI: prod_q[2*W-1:W] <= prod_q[2*W-1:W] + W'(carry_q);
      ST_REM_WAIT: if (div_done) res_q <= (modulus_q == '0) ? '0 : div_rem;
      ST_RD_M_WAIT: if (mul_done) m_q <= mul_prod[L-1:0];
      ST_RD_N_WAIT: if (mul_done) prod_q <= mul_prod;
      ST_RD_UPD: begin
        tlo_q  <= rd_tlo;
        thi_q  <= rd_thi >> L;
        limb_q <= limb_q + 1'b1;
      end
      ST_RD_FIN: res_q <= (tlo_q >= modulus_q) ? tlo_q - modulus_q : tlo_q;
      ST_INV_DIV_WAIT: begin
        if (div_done) begin
          q_q  <= div_quo;
          nr_q <= div_rem;
        end
      end
      ST_INV_MUL_WAIT: begin
        if (mul_done) begin
          t1_q <= t0_q - mul_prod[W-1:0];
          t0_q <= t1_q;
          r0_q <= r1_q;
          r1_q <= nr_q;
        end
      end
      ST_INV_FIN: begin
        res_q  <= inv_res;
        op_a_q <= r2_q;
        op_b_q <= inv_res;
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_q);

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q == ST_DISP)
    else $error("accepted transaction did not start");

  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_REM_WAIT && div_done && modulus_q != '0 |-> div_rem < modulus_q)
    else $error("remainder not reduced");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == ST_DONE)
    else $error("result without finished transaction");

  a_single_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_start && div_start))
    else $error("multiplier and divider started together");
`endif

endmodule

// ===== bench/modular_arith_unit_tb.sv =====
module modular_arith_unit_tb;
  import mau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 3_000_000;

  class mod_alu_scoreboard;
    bit [63:0] modulus;
    bit [31:0] n_prime;
    bit [63:0] r_squared;
    bit        mont_mode;
    bit [63:0] expected_q[$];
    int        errors;

    function new();
      modulus   = MODULUS_RST;
      n_prime   = N_PRIME_RST;
      r_squared = R_SQUARED_RST;
      mont_mode = 1'b0;
      errors    = 0;
    endfunction

    function void set_reg(cfg_e idx, bit [63:0] val);
      case (idx)
        CFG_MODULUS:   modulus   = val;
        CFG_N_PRIME:   n_prime   = val[31:0];
        CFG_R_SQUARED: r_squared = val;
        CFG_MONT_MODE: mont_mode = val[0];
      endcase
    endfunction

    function bit [63:0] wide_rem(bit [127:0] v);
      if (modulus == 0) return 64'd0;
      return 64'(v % {64'd0, modulus});
    endfunction

    // two 32-bit limb steps, high half wraps at 64 bits
    function bit [63:0] redc(bit [63:0] tlo, bit [63:0] thi);
      bit [31:0]  m;
      bit [127:0] prod;
      bit [64:0]  s;
      for (int i = 0; i < 2; i++) begin
        m    = 32'(tlo[31:0] * n_prime);
        prod = {64'd0, modulus} * {96'd0, m};
        s    = {1'b0, tlo} + {1'b0, prod[63:0]};
        tlo  = s[63:0];
        thi  = thi + prod[127:64] + {63'd0, s[64]};
        tlo  = (tlo >> 32) | {thi[31:0], 32'd0};
        thi  = thi >> 32;
      end
      if (tlo >= modulus) tlo = tlo - modulus;
      return tlo;
    endfunction

    function bit [63:0] mont_product(bit [63:0] a, bit [63:0] b);
      bit [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return redc(p[63:0], p[127:64]);
    endfunction

    function bit [63:0] euclid_inverse(bit [63:0] a);
      bit [63:0] r0, r1, t0, t1, q, nr, nt;
      r0 = modulus; r1 = a; t0 = 0; t1 = 1;
      while (r1 != 0) begin
        q  = r0 / r1;
        nr = r0 % r1;
        nt = t0 - t1 * q;
        r0 = r1; r1 = nr; t0 = t1; t1 = nt;
      end
      if (r0 != 1) return 64'd0;
      if (t0[63]) t0 = t0 + modulus;
      return t0;
    endfunction

    function bit [63:0] compute(bit [3:0] act, bit [63:0] a, bit [63:0] b, bit [63:0] acc);
      bit [64:0]  s;
      bit [127:0] p;
      case (act)
        ACT_ADD: begin
          s = {1'b0, a} + {1'b0, b};
          if (s[64] || s[63:0] >= modulus) s[63:0] = s[63:0] - modulus;
          return s[63:0];
        end
        ACT_SUB:       return (a >= b) ? a - b : a - b + modulus;
        ACT_NEG:       return modulus - a;
        ACT_MUL: begin
          if (mont_mode) return mont_product(a, b);
          return wide_rem({64'd0, a} * {64'd0, b});
        end
        ACT_MAC: begin
          p = {64'd0, a} * {64'd0, b} + {64'd0, acc};
          return wide_rem(p);
        end
        ACT_MONT_RED:  return redc(a, b);
        ACT_TO_MONT:   return mont_product(a, r_squared);
        ACT_FROM_MONT: return redc(a, 64'd0);
        ACT_INV: begin
          if (mont_mode)
            return wide_rem({64'd0, r_squared} * {64'd0, euclid_inverse(a)});
          return euclid_inverse(a);
        end
        default:       return 64'd0;
      endcase
    endfunction

    function void note_input(bit [3:0] act, bit [63:0] a, bit [63:0] b, bit [63:0] acc);
      expected_q.insert(expected_q.size(), compute(act, a, b, acc));
    endfunction

    function void check_result(bit [63:0] got);
      bit [63:0] exp_v;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction, result_value %h", got);
        errors++;
        return;
      end
      exp_v = expected_q.pop_front();
      if (exp_v !== got) begin
        $error("result_value mismatch: expected %h actual %h", exp_v, got);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [1:0]             cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  mod_alu_scoreboard sb;
  longint            cycles;
  bit                rx_hold;
  int                stall_pct;
  int                burst_left;
  bit                no_gaps;

  modular_arith_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit [63:0] pick_operand();
    bit [63:0] n;
    n = sb.modulus;
    case ($urandom_range(7))
      0: return 64'd0;
      1: return '1;
      2: return n - 1;
      3: return 64'($urandom_range(20));
      4, 5: return (n != 0) ? rand64() % n : rand64();
      default: return rand64();
    endcase
  endfunction

  function automatic bit [3:0] pick_action();
    int r;
    r = $urandom_range(99);
    if (r < 3) return ACT_INV;
    if (r < 7) return 4'($urandom_range(15, 9));
    return 4'($urandom_range(7));
  endfunction

  // one transaction; valid stays high across back-to-back items of a burst
  task automatic send_item(bit [3:0] act, bit [63:0] a, bit [63:0] b, bit [63:0] acc);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(16, 1);
      gap = no_gaps ? 0 : (($urandom_range(9) == 0) ? $urandom_range(40, 10)
                                                  : $urandom_range(6));
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, acc, b, a, act};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(act, a, b, acc);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_e idx, bit [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // -N^-1 mod 2^32 by Newton iteration, R^2 = (2^64 mod N)^2 mod N
  task automatic setup_montgomery(bit [63:0] n);
    bit [31:0]  inv;
    bit [127:0] r;
    inv = n[31:0];
    repeat (5) inv = inv * (32'd2 - n[31:0] * inv);
    r = (128'd1 << 64) % {64'd0, n};
    r = (r * r) % {64'd0, n};
    write_reg(CFG_MODULUS, n);
    write_reg(CFG_N_PRIME, {32'd0, -inv});
    write_reg(CFG_R_SQUARED, r[63:0]);
  endtask

  task automatic random_items(int count);
    bit [3:0] act;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        no_gaps   = ($urandom_range(3) == 0);
        stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(70);
      end
      act = pick_action();
      send_item(act, pick_operand(), pick_operand(), pick_operand());
    end
  endtask

  initial begin
    bit [63:0] odd_n;
    sb            = new();
    cycles        = 0;
    rx_hold       = 1'b0;
    stall_pct     = 20;
    burst_left    = 0;
    no_gaps       = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_MODULUS;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, every action, unused codes, inverse corner cases
    send_item(ACT_ADD, '1, '1, 0);
    send_item(ACT_ADD, 0, 0, 0);
    send_item(ACT_ADD, MODULUS_RST - 1, 64'd1, 0);
    send_item(ACT_SUB, 0, '1, 0);
    send_item(ACT_SUB, '1, 0, 0);
    send_item(ACT_NEG, 0, 0, 0);
    send_item(ACT_NEG, '1, 0, 0);
    send_item(ACT_MUL, '1, '1, 0);
    send_item(ACT_MAC, '1, '1, '1);
    send_item(ACT_MAC, 0, 0, '1);
    send_item(ACT_MONT_RED, '1, '1, 0);
    send_item(ACT_MONT_RED, 0, 0, 0);
    send_item(ACT_TO_MONT, '1, 0, 0);
    send_item(ACT_FROM_MONT, '1, 0, 0);
    send_item(ACT_INV, 0, 0, 0);
    send_item(ACT_INV, 64'd1, 0, 0);
    send_item(ACT_INV, 64'd12345, 0, 0);
    send_item(4'd9, '1, '1, '1);
    send_item(4'd15, '1, '1, '1);

    // long receiver hold-off so the input backs up
    fork
      begin
        rx_hold = 1'b1;
        repeat (600) @(posedge clk_i);
        rx_hold = 1'b0;
      end
    join_none
    random_items(180);
    drain();

    write_reg(CFG_MODULUS, '1);
    write_reg(CFG_N_PRIME, {32'd0, $urandom});
    write_reg(CFG_R_SQUARED, rand64());
    write_reg(CFG_MONT_MODE, 64'd1);
    send_item(ACT_MUL, '1, '1, 0);
    send_item(ACT_INV, 64'd3, 0, 0);
    random_items(150);
    drain();

    odd_n = rand64() | 64'd1;
    setup_montgomery(odd_n);
    random_items(200);
    drain();

    write_reg(CFG_MODULUS, 64'd2);
    write_reg(CFG_N_PRIME, 64'd0);
    write_reg(CFG_R_SQUARED, 64'd0);
    write_reg(CFG_MONT_MODE, 64'd0);
    random_items(100);
    drain();

    // even modulus: many operands share a factor, inverse gives 0
    write_reg(CFG_MODULUS, rand64() & ~64'd1);
    write_reg(CFG_N_PRIME, 64'hFFFF_FFFF);
    write_reg(CFG_R_SQUARED, '1);
    write_reg(CFG_MONT_MODE, 64'd1);
    send_item(ACT_INV, 64'd4, 0, 0);
    random_items(150);
    drain();

    setup_montgomery(MODULUS_RST);
    random_items(200);
    drain();

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
